FILE: sv/prc_pkg.sv
package prc_pkg;

  localparam int SYM_BITS      = 32;
  localparam int QUO_BITS      = 64;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 64;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DIV = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE_AMOUNT  = 2'd0,
    REG_BASE_SYMBOL  = 2'd1,
    REG_QUOTE_AMOUNT = 2'd2,
    REG_QUOTE_SYMBOL = 2'd3
  } reg_idx_t;

endpackage

FILE: sv/price_ratio_convert.sv
// price ratio converter: each item carries an amount and the asset symbol it
// is denominated in. if the symbol matches the base side of the configured
// price the result is amount * quote_amount / base_amount tagged with the
// quote symbol; if it matches the quote side the roles swap (base is tested
// first). the full double-width product is divided with truncation. status
// in m_tuser: ok, zero divisor, quotient not fitting 64 bits, or no symbol
// match; on any error amount and symbol out are zero. the block takes one
// item per clock when the output side keeps up. the pipe holds one select
// stage, three multiplier stages (partial products of at most 32 by 32
// bits, cross-term sum, final add), one overflow-check stage and 64
// divider stages that each resolve one quotient bit. a skid register at the
// output holds one finished item so that input is still taken in the cycle
// a stall starts; the whole pipe then holds until the skid drains.
// configuration must be written over the apb port only while the block is
// idle (not enforced); registers: byte addresses 0, 8, 16, 24, 64-bit data.
module price_ratio_convert #(
  parameter int AMOUNT_BITS = 63
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // apb configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [prc_pkg::CFG_ADDR_BITS-1:0]          paddr,
  input  logic [prc_pkg::CFG_DATA_BITS-1:0]          pwdata,
  output logic [prc_pkg::CFG_DATA_BITS-1:0]          prdata,
  output logic                                       pready,
  // input stream
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // fields from bit 0: amount_in, symbol_in, zero fill
  input  logic [((AMOUNT_BITS+prc_pkg::SYM_BITS+7)/8)*8-1:0] s_tdata,
  // output stream
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // fields from bit 0: amount_out, symbol_out
  output logic [prc_pkg::QUO_BITS+prc_pkg::SYM_BITS-1:0] m_tdata,
  // fields from bit 0: status
  output logic [prc_pkg::STATUS_BITS-1:0]            m_tuser
);

  import prc_pkg::*;

  localparam int N          = AMOUNT_BITS;
  localparam int PW         = 2 * N;
  localparam int MUL_STAGES = 3;
  localparam int DIV_STAGES = QUO_BITS;

  // configuration registers
  logic [N-1:0]        base_amount, quote_amount;
  logic [SYM_BITS-1:0] base_symbol, quote_symbol;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_amount  <= N'(1);
      base_symbol  <= '0;
      quote_amount <= N'(1);
      quote_symbol <= SYM_BITS'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[4:3]))
        REG_BASE_AMOUNT:  base_amount  <= pwdata[N-1:0];
        REG_BASE_SYMBOL:  base_symbol  <= pwdata[SYM_BITS-1:0];
        REG_QUOTE_AMOUNT: quote_amount <= pwdata[N-1:0];
        REG_QUOTE_SYMBOL: quote_symbol <= pwdata[SYM_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:3]))
      REG_BASE_AMOUNT:  prdata = CFG_DATA_BITS'(base_amount);
      REG_BASE_SYMBOL:  prdata = CFG_DATA_BITS'(base_symbol);
      REG_QUOTE_AMOUNT: prdata = CFG_DATA_BITS'(quote_amount);
      REG_QUOTE_SYMBOL: prdata = CFG_DATA_BITS'(quote_symbol);
    endcase
  end

  // global advance: the pipe moves whenever the skid is empty
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // stage 0: symbol match and operand select
  logic [N-1:0]        amt_in;
  logic [SYM_BITS-1:0] sym_in;
  logic [N-1:0]        sel_mulby, sel_divby;
  logic [SYM_BITS-1:0] sel_tag;
  status_t             sel_status;

  assign amt_in = s_tdata[N-1:0];
  assign sym_in = s_tdata[N+SYM_BITS-1:N];

  always_comb begin
    sel_mulby  = quote_amount;
    sel_divby  = base_amount;
    sel_tag    = quote_symbol;
    sel_status = ST_OK;
    if (sym_in == base_symbol) begin
      sel_mulby = quote_amount;
      sel_divby = base_amount;
      sel_tag   = quote_symbol;
    end else if (sym_in == quote_symbol) begin
      sel_mulby = base_amount;
      sel_divby = quote_amount;
      sel_tag   = base_symbol;
    end else begin
      sel_status = ST_NO_MATCH;
    end
    if (sel_status == ST_OK && sel_divby == '0) begin
      sel_status = ST_ZERO_DIV;
    end
  end

  logic                s0_valid;
  logic [N-1:0]        s0_amt, s0_mulby, s0_divby;
  logic [SYM_BITS-1:0] s0_tag;
  status_t             s0_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_amt    <= amt_in;
      s0_mulby  <= sel_mulby;
      s0_divby  <= sel_divby;
      s0_tag    <= sel_tag;
      s0_status <= sel_status;
    end
  end

  // stages 1..3: product, with side data delayed alongside
  logic [PW-1:0] prod;

  prc_mult #(
    .W (N)
  ) u_mult (
    .clk (clk),
    .en  (en),
    .a   (s0_amt),
    .b   (s0_mulby),
    .p   (prod)
  );

  logic [MUL_STAGES-1:0] mv;
  logic [N-1:0]          md     [MUL_STAGES];
  logic [SYM_BITS-1:0]   mtag   [MUL_STAGES];
  status_t               mstat  [MUL_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[MUL_STAGES-2:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md[0]    <= s0_divby;
      mtag[0]  <= s0_tag;
      mstat[0] <= s0_status;
      for (int k = 1; k < MUL_STAGES; k++) begin
        md[k]    <= md[k-1];
        mtag[k]  <= mtag[k-1];
        mstat[k] <= mstat[k-1];
      end
    end
  end

  // stage 4: overflow check, split into remainder and low dividend word
  logic [2*QUO_BITS-1:0] prod_ext;
  logic [QUO_BITS-1:0]   prod_hi;
  logic                  ovf;
  status_t               chk_status;

  assign prod_ext = (2*QUO_BITS)'(prod);
  assign prod_hi  = prod_ext[2*QUO_BITS-1:QUO_BITS];
  assign ovf      = prod_hi >= QUO_BITS'(md[MUL_STAGES-1]);

  always_comb begin
    chk_status = mstat[MUL_STAGES-1];
    if (chk_status == ST_OK && ovf) begin
      chk_status = ST_OVERFLOW;
    end
  end

  // divider pipe: entry 0 is the check stage, entry k holds k quotient bits
  logic                dv    [DIV_STAGES+1];
  logic [N-1:0]        drem  [DIV_STAGES+1];
  logic [QUO_BITS-1:0] dlo   [DIV_STAGES+1];
  logic [QUO_BITS-1:0] dq    [DIV_STAGES+1];
  logic [N-1:0]        dd    [DIV_STAGES+1];
  logic [SYM_BITS-1:0] dtag  [DIV_STAGES+1];
  status_t             dstat [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= mv[MUL_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]  <= prod_hi[N-1:0];
      dlo[0]   <= prod_ext[QUO_BITS-1:0];
      dq[0]    <= '0;
      dd[0]    <= md[MUL_STAGES-1];
      dtag[0]  <= mtag[MUL_STAGES-1];
      dstat[0] <= chk_status;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [N:0]          trial;
    logic [N:0]          diff;
    logic                take;
    logic [N-1:0]        rem_next;
    logic [QUO_BITS-1:0] q_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {drem[k-1], dlo[k-1][QUO_BITS-1]};
    assign diff     = trial - {1'b0, dd[k-1]};
    assign take     = trial >= {1'b0, dd[k-1]};
    assign rem_next = take ? diff[N-1:0] : trial[N-1:0];
    assign q_next   = {dq[k-1][QUO_BITS-2:0], take};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k]  <= rem_next;
        dlo[k]   <= {dlo[k-1][QUO_BITS-2:0], 1'b0};
        dd[k]    <= dd[k-1];
        dstat[k] <= dstat[k-1];
        if (k == DIV_STAGES && dstat[k-1] != ST_OK) begin
          // error items leave with zero amount and symbol
          dq[k]   <= '0;
          dtag[k] <= '0;
        end else begin
          dq[k]   <= q_next;
          dtag[k] <= dtag[k-1];
        end
      end
    end
  end

  // output skid: catches the last stage's item when the sink stalls
  logic [QUO_BITS-1:0] skid_q;
  logic [SYM_BITS-1:0] skid_tag;
  status_t             skid_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (dv[DIV_STAGES] && !m_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skid_q    <= dq[DIV_STAGES];
      skid_tag  <= dtag[DIV_STAGES];
      skid_stat <= dstat[DIV_STAGES];
    end
  end

  // the skid item is older than the last stage, so it goes first
  assign m_tvalid = skid_valid || dv[DIV_STAGES];
  assign m_tdata  = skid_valid ? {skid_tag, skid_q} : {dtag[DIV_STAGES], dq[DIV_STAGES]};
  assign m_tuser  = skid_valid ? skid_stat : dstat[DIV_STAGES];

endmodule

FILE: sv/prc_mult.sv
module prc_mult #(
  parameter int W = 63
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  localparam int LW = (W + 1) / 2;
  localparam int HW = W - LW;

  logic [LW-1:0]      a_l, b_l;
  logic [HW-1:0]      a_h, b_h;
  logic [2*LW-1:0]    pll, pll2;
  logic [LW+HW-1:0]   plh, phl;
  logic [2*HW-1:0]    phh, phh2;
  logic [LW+HW:0]     mid;

  assign a_l = a[LW-1:0];
  assign a_h = a[W-1:LW];
  assign b_l = b[LW-1:0];
  assign b_h = b[W-1:LW];

  // stage 1: four narrow partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pll <= (2*LW)'(a_l) * (2*LW)'(b_l);
      plh <= (LW+HW)'(a_l) * (LW+HW)'(b_h);
      phl <= (LW+HW)'(a_h) * (LW+HW)'(b_l);
      phh <= (2*HW)'(a_h) * (2*HW)'(b_h);
    end
  end

  // stage 2: cross terms summed
  always_ff @(posedge clk) begin
    if (en) begin
      mid  <= {1'b0, plh} + {1'b0, phl};
      pll2 <= pll;
      phh2 <= phh;
    end
  end

  // stage 3: final alignment and add
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (2*W)'(pll2) + ((2*W)'(mid) << LW) + ((2*W)'(phh2) << (2*LW));
    end
  end

endmodule
